[rtl/tat_pkg.sv]
package tat_pkg;

  localparam int ACC_W        = 16;
  localparam int ANG_W        = 18;
  localparam int PIX_W        = 8;
  localparam int GAIN_W       = 16;
  localparam int CX_W         = 7;
  localparam int CY_W         = 6;
  localparam int LEN_W        = 6;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IDX_W       = 5;
  localparam int ATAN_W           = 30;
  localparam int DW               = 39;
  localparam int ZW               = 34;
  localparam int KQ_W             = 30;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd6554;
  localparam logic [CX_W-1:0]   CX_RST   = 7'd64;
  localparam logic [CY_W-1:0]   CY_RST   = 6'd32;
  localparam logic [LEN_W-1:0]  LEN_RST  = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CX   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CY   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 8'd3;

  typedef enum logic {
    CORDIC_VEC,
    CORDIC_ROT
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10680862;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tat_ifs.sv]
interface tat_in_if import tat_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink (input valid, input accel_x, input accel_y, output ready);
endinterface

interface tat_out_if import tat_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] smoothed_angle;
  logic [PIX_W-1:0]        end_x;
  logic [PIX_W-1:0]        end_y;
  modport source (output valid, output smoothed_angle, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input smoothed_angle, input end_x, input end_y,
                output ready);
endinterface

interface tat_cfg_if import tat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

[rtl/tat_cordic.sv]
module tat_cordic import tat_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_ctl_t          ctl,
  input  logic signed [DW-1:0] x_init,
  input  logic signed [DW-1:0] y_init,
  input  logic signed [ZW-1:0] z_init,
  output logic signed [DW-1:0] x_out,
  output logic signed [DW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output cordic_stat_t         stat
);

  localparam int IW = $clog2(STEPS);

  cordic_mode_t         mode_r;
  logic [IW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic signed [DW-1:0] x_r;
  logic signed [DW-1:0] y_r;
  logic signed [ZW-1:0] z_r;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] ang;
  logic                 up;
  logic signed [DW-1:0] x_nxt;
  logic signed [DW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;

  assign dx  = x_r >>> cnt_r;
  assign dy  = y_r >>> cnt_r;
  assign ang = ZW'($signed({1'b0, atan_lut(ATAN_IDX_W'(cnt_r))}));
  assign up  = (mode_r == CORDIC_ROT) ? !z_r[ZW-1] : y_r[DW-1];

  always_comb begin
    if (up) begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - ang;
    end else begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= CORDIC_VEC;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mode_r <= ctl.mode;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r <= x_init;
      y_r <= y_init;
      z_r <= z_init;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/tilt_angle_tracker_core.sv]
// Tilt angle tracker.
// in_bus carries one accelerometer beat (accel_x, accel_y). in_bus.ready is high only
// while the block is idle; one beat is worked on at a time.
// out_bus carries one result beat per input beat: the low-passed angle in units of
// pi/32768 rad and the pointer end point (end_x, end_y), clamped to 0..255.
// cfg_bus writes filter_gain (0), center_x (1), center_y (2), pointer_length (3);
// other indexes are dropped. cfg_bus.ready is always high; write only while idle.
// One CORDIC unit does both the atan2 vectoring pass and the cos/sin rotation pass,
// one micro-rotation per cycle. A new input beat is taken the cycle after the result
// is loaded.
// The result sits in an output register; a stalled receiver holds it while the next
// beat is worked on, and the following result waits until the register frees.
// Reset (rst_n low, synchronous) returns the registers to their defaults, clears the
// filtered angle to zero and drops out_bus.valid.
module tilt_angle_tracker_core import tat_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tat_in_if.sink    in_bus,
  tat_out_if.source out_bus,
  tat_cfg_if.sink   cfg_bus
);

  localparam longint unsigned KQ30 = 64'd652032874 +
    ((64'd434688583 + ((64'd1 << (2 * CORDIC_STEPS)) >> 1)) >> (2 * CORDIC_STEPS));
  localparam logic [KQ_W-1:0] K_GAIN = KQ_W'(KQ30);
  localparam logic signed [ZW-1:0] PI31 = ZW'(64'sd2147483648);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VEC,
    S_UNWRAP,
    S_MUL,
    S_UPD,
    S_ROT,
    S_FIN
  } state_t;

  state_t                  state_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [CX_W-1:0]         cx_r;
  logic [CY_W-1:0]         cy_r;
  logic [LEN_W-1:0]        len_r;
  logic                    zero_r;
  logic signed [ANG_W-1:0] filt_r;
  logic signed [ANG_W-1:0] t0a_r;
  logic signed [ANG_W-1:0] diff_r;
  logic signed [34:0]      prod_r;
  logic [KQ_W+LEN_W-1:0]   kl_r;
  logic                    flip_r;
  logic                    out_valid_r;
  logic signed [ANG_W-1:0] ang_out_r;
  logic [PIX_W-1:0]        ex_r;
  logic [PIX_W-1:0]        ey_r;

  cordic_ctl_t          cdc_ctl;
  cordic_stat_t         cdc_stat;
  logic signed [DW-1:0] cdc_x0;
  logic signed [DW-1:0] cdc_y0;
  logic signed [ZW-1:0] cdc_z0;
  logic signed [DW-1:0] cdc_x;
  logic signed [DW-1:0] cdc_y;
  logic signed [ZW-1:0] cdc_z;

  logic                    in_acc;
  logic signed [DW-1:0]    vx0;
  logic signed [DW-1:0]    vy0;
  logic signed [ZW-1:0]    zsum;
  logic signed [ANG_W-1:0] zsh;
  logic signed [ANG_W-1:0] raw_nxt;
  logic signed [ANG_W:0]   d0;
  logic signed [ANG_W-1:0] t0a_nxt;
  logic signed [ANG_W-1:0] diff_nxt;
  logic signed [34:0]      prod_nxt;
  logic signed [34:0]      prnd;
  logic signed [ANG_W-1:0] filt_nxt;
  logic signed [16:0]      a_w;
  logic signed [16:0]      a_nxt;
  logic                    flip_nxt;
  logic signed [DW-1:0]    vx_f;
  logic signed [DW-1:0]    vy_f;
  logic [PIX_W-1:0]        ex_nxt;
  logic [PIX_W-1:0]        ey_nxt;
  logic                    out_free;

  function automatic logic [PIX_W-1:0] sat_point(input logic [CX_W-1:0] ctr,
                                                  input logic signed [DW-1:0] v);
    logic signed [DW-1:0] vr;
    logic signed [10:0]   p;
    vr = (v + DW'(64'sd4194304)) >>> 30;
    p  = 11'($signed({1'b0, ctr})) + 11'(vr);
    if (p < 0) begin
      return '0;
    end else if (p > 11'sd255) begin
      return '1;
    end
    return p[PIX_W-1:0];
  endfunction

  tat_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cdc_ctl),
    .x_init (cdc_x0),
    .y_init (cdc_y0),
    .z_init (cdc_z0),
    .x_out  (cdc_x),
    .y_out  (cdc_y),
    .z_out  (cdc_z),
    .stat   (cdc_stat)
  );

  assign in_acc = in_bus.valid && in_bus.ready;
  assign vx0    = DW'(in_bus.accel_y) <<< 16;
  assign vy0    = DW'(in_bus.accel_x) <<< 16;

  // raw angle: round to pi/32768, clamp to +-pi, zero for a zero input
  assign zsum = cdc_z + ZW'(32'sd32768);
  assign zsh  = zsum[ANG_W+15:16];
  always_comb begin
    if (zero_r) begin
      raw_nxt = '0;
    end else if (zsh > ANG_W'(32'sd32768)) begin
      raw_nxt = ANG_W'(32'sd32768);
    end else if (zsh < -ANG_W'(32'sd32768)) begin
      raw_nxt = -ANG_W'(32'sd32768);
    end else begin
      raw_nxt = zsh;
    end
  end

  // unwrap kept angle toward raw
  assign d0 = (ANG_W+1)'(filt_r) - (ANG_W+1)'(raw_nxt);
  always_comb begin
    if (d0 > (ANG_W+1)'(32'sd32768)) begin
      t0a_nxt = filt_r - ANG_W'(32'sd65536);
    end else if (d0 < -(ANG_W+1)'(32'sd32768)) begin
      t0a_nxt = filt_r + ANG_W'(32'sd65536);
    end else begin
      t0a_nxt = filt_r;
    end
  end
  assign diff_nxt = raw_nxt - t0a_nxt;

  // (1-g)*old + g*raw == old + g*(raw-old)
  assign prod_nxt = 35'($signed({1'b0, gain_r})) * 35'(diff_r);
  assign prnd     = (prod_r + 35'sd32768) >>> 16;
  assign filt_nxt = t0a_r + ANG_W'(prnd);

  assign a_w = 17'($signed(filt_nxt[15:0]));
  always_comb begin
    if (a_w > 17'sd16384) begin
      a_nxt    = a_w - 17'sd32768;
      flip_nxt = 1'b1;
    end else if (a_w < -17'sd16384) begin
      a_nxt    = a_w + 17'sd32768;
      flip_nxt = 1'b1;
    end else begin
      a_nxt    = a_w;
      flip_nxt = 1'b0;
    end
  end

  always_comb begin
    cdc_ctl.start = 1'b0;
    cdc_ctl.mode  = CORDIC_VEC;
    cdc_x0        = vx0;
    cdc_y0        = vy0;
    cdc_z0        = '0;
    case (state_r)
      S_IDLE: begin
        cdc_ctl.start = in_acc;
        if (in_bus.accel_y < 0) begin
          cdc_x0 = -vx0;
          cdc_y0 = -vy0;
          cdc_z0 = (in_bus.accel_x >= 0) ? PI31 : -PI31;
        end
      end
      S_UPD: begin
        cdc_ctl.start = 1'b1;
        cdc_ctl.mode  = CORDIC_ROT;
        cdc_x0        = DW'(kl_r);
        cdc_y0        = '0;
        cdc_z0        = ZW'(a_nxt) <<< 16;
      end
      default: begin
        cdc_ctl.start = 1'b0;
      end
    endcase
  end

  assign vx_f     = flip_r ? -cdc_x : cdc_x;
  assign vy_f     = flip_r ? -cdc_y : cdc_y;
  assign ex_nxt   = sat_point(cx_r, vx_f);
  assign ey_nxt   = sat_point(CX_W'(cy_r), vy_f);
  assign out_free = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RST;
      cx_r        <= CX_RST;
      cy_r        <= CY_RST;
      len_r       <= LEN_RST;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.idx)
          CFG_GAIN: gain_r <= cfg_bus.data[GAIN_W-1:0];
          CFG_CX:   cx_r   <= cfg_bus.data[CX_W-1:0];
          CFG_CY:   cy_r   <= cfg_bus.data[CY_W-1:0];
          CFG_LEN:  len_r  <= cfg_bus.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            zero_r  <= (in_bus.accel_x == '0) && (in_bus.accel_y == '0);
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          if (cdc_stat.done) begin
            state_r <= S_UNWRAP;
          end
        end
        S_UNWRAP: begin
          t0a_r   <= t0a_nxt;
          diff_r  <= diff_nxt;
          kl_r    <= K_GAIN * len_r;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_UPD;
        end
        S_UPD: begin
          filt_r  <= filt_nxt;
          flip_r  <= flip_nxt;
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (cdc_stat.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            ang_out_r <= filt_r;
            ex_r      <= ex_nxt;
            ey_r      <= ey_nxt;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_bus.ready           = (state_r == S_IDLE);
  assign cfg_bus.ready          = 1'b1;
  assign out_bus.valid          = out_valid_r;
  assign out_bus.smoothed_angle = ang_out_r;
  assign out_bus.end_x          = ex_r;
  assign out_bus.end_y          = ey_r;

`ifndef SYNTHESIS
  a_start_vec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_VEC) && cdc_stat.busy)
    else $error("input beat did not start vectoring pass");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cdc_stat.done |-> (state_r == S_VEC || state_r == S_ROT))
    else $error("cordic done outside a pass");

  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_r <= ANG_W'(32'sd65536)) && (filt_r >= -ANG_W'(32'sd65536)))
    else $error("filtered angle out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside final state");
`endif

endmodule

[tb/sv/tilt_angle_tracker_core_checker.sv]
module tilt_angle_tracker_core_checker import tat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tat_in_if    in_bus,
  tat_out_if   out_bus,
  tat_cfg_if   cfg_bus,
  output int   mismatch_count,
  output int   poses_due
);

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint PI_Q31 = 64'sd2147483648;
  // atan(2^-i), units of pi/2^31
  localparam longint ARC_Q31 [0:ATAN_LEN-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087, 667544,
    333772, 166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [PIX_W-1:0] end_x;
    logic [PIX_W-1:0] end_y;
  } pose_t;

  logic [GAIN_W-1:0] gain;
  logic [CX_W-1:0]   cx;
  logic [CY_W-1:0]   cy;
  logic [LEN_W-1:0]  len_px;
  longint            tracked_angle;
  longint            raw_angle;
  pose_t             pose_q [$];
  pose_t             want;
  int                fails = 0;
  int                due = 0;

  assign mismatch_count = fails;
  assign poses_due      = due;

  function automatic longint tilt_atan2(input longint x, input longint y);
    longint vx, vy, z, dx, dy, r;
    if (x == 0 && y == 0) return 0;
    vx = y * 65536;
    vy = x * 65536;
    z  = 0;
    if (vx < 0) begin
      z  = (vy >= 0) ? PI_Q31 : -PI_Q31;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (vy >= 0) begin
        vx += dy;
        vy -= dx;
        z  += ARC_Q31[i];
      end else begin
        vx -= dy;
        vy += dx;
        z  -= ARC_Q31[i];
      end
    end
    r = (z + 32768) >>> 16;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint blend_angle(input longint prev, input longint raw);
    longint g;
    g = gain;
    // unwrap by one turn toward the new sample
    if (prev - raw > 32768) prev -= 65536;
    else if (raw - prev > 32768) prev += 65536;
    return ((65536 - g) * prev + g * raw + 32768) >>> 16;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pixel(input longint center, input longint v);
    longint p;
    p = center + ((v + (64'sd1 <<< 22)) >>> 30);
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return p[PIX_W-1:0];
  endfunction

  function automatic void pointer_end(input longint angle,
                                      output logic [PIX_W-1:0] ex,
                                      output logic [PIX_W-1:0] ey);
    longint a, k, lenv, vx, vy, z, dx, dy, cxv, cyv;
    bit flip;
    a    = longint'((angle + 32768) & 64'hFFFF) - 32768;
    flip = 0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    k    = 64'sd652032874 +
           ((64'sd434688583 + ((64'sd1 <<< (2 * STEPS)) >>> 1)) >>> (2 * STEPS));
    lenv = len_px;
    vx   = k * lenv;
    vy   = 0;
    z    = a * 65536;
    for (int i = 0; i < STEPS; i++) begin
      dx = vx >>> i;
      dy = vy >>> i;
      if (z >= 0) begin
        vx -= dy;
        vy += dx;
        z  -= ARC_Q31[i];
      end else begin
        vx += dy;
        vy -= dx;
        z  += ARC_Q31[i];
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    cxv = cx;
    cyv = cy;
    ex  = clamp_pixel(cxv, vx);
    ey  = clamp_pixel(cyv, vy);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain          = 16'd6554;
      cx            = 7'd64;
      cy            = 6'd32;
      len_px        = 6'd32;
      tracked_angle = 0;
      pose_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pose_q.size() == 0) begin
          $error("result beat with nothing expected: smoothed_angle %0d end_x %0d end_y %0d",
                 out_bus.smoothed_angle, out_bus.end_x, out_bus.end_y);
          fails++;
        end else begin
          want = pose_q.pop_front();
          if (out_bus.smoothed_angle !== want.angle) begin
            $error("smoothed_angle: expected %0d, got %0d",
                   $signed(want.angle), out_bus.smoothed_angle);
            fails++;
          end
          if (out_bus.end_x !== want.end_x) begin
            $error("end_x: expected %0d, got %0d", want.end_x, out_bus.end_x);
            fails++;
          end
          if (out_bus.end_y !== want.end_y) begin
            $error("end_y: expected %0d, got %0d", want.end_y, out_bus.end_y);
            fails++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        raw_angle     = tilt_atan2(in_bus.accel_x, in_bus.accel_y);
        tracked_angle = blend_angle(tracked_angle, raw_angle);
        want.angle    = tracked_angle[ANG_W-1:0];
        pointer_end(tracked_angle, want.end_x, want.end_y);
        pose_q.push_back(want);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.idx)
          CFG_GAIN: gain   = cfg_bus.data[GAIN_W-1:0];
          CFG_CX:   cx     = cfg_bus.data[CX_W-1:0];
          CFG_CY:   cy     = cfg_bus.data[CY_W-1:0];
          CFG_LEN:  len_px = cfg_bus.data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    due <= pose_q.size();
  end

endmodule

[tb/sv/tilt_angle_tracker_core_test.sv]
module tilt_angle_tracker_core_test;
  import tat_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_SAMPLES = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 8'd255;

  logic clk;
  logic rst_n;
  bit   steady;
  int   cycles;
  int   mismatches;
  int   poses_due;

  tat_in_if  in_bus ();
  tat_out_if out_bus ();
  tat_cfg_if cfg_bus ();

  tilt_angle_tracker_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  tilt_angle_tracker_core_checker pose_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .cfg_bus        (cfg_bus),
    .mismatch_count (mismatches),
    .poses_due      (poses_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= rst_n && (steady || $urandom_range(0, 99) >= 32);
  end

  task automatic send_sample(input logic signed [ACC_W-1:0] x,
                             input logic signed [ACC_W-1:0] y);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.accel_x <= x;
    in_bus.accel_y <= y;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (poses_due != 0) @(posedge clk);
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(0, 4))
      0:       g = '0;
      1:       g = '1;
      2:       g = CFG_DATA_W'($urandom);
      default: g = CFG_DATA_W'($urandom_range(1000, 20000));
    endcase
    write_reg(CFG_GAIN, g);
    write_reg(CFG_CX, CFG_DATA_W'($urandom));
    write_reg(CFG_CY, CFG_DATA_W'($urandom));
    write_reg(CFG_LEN, CFG_DATA_W'($urandom));
  endtask

  // returns how many beats were sent
  task automatic random_sample(output int sent);
    logic signed [ACC_W-1:0] x, y;
    int burst;
    sent = 1;
    case ($urandom_range(0, 8))
      5: begin
        x = ACC_W'($urandom_range(0, 8) - 4);
        y = ACC_W'($urandom_range(0, 8) - 4);
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          x = 0;
          y = ACC_W'($urandom);
        end else begin
          x = ACC_W'($urandom);
          y = 0;
        end
      end
      7: begin
        // run along the negative y axis, x sign flipping across +/-pi
        burst = $urandom_range(4, 12);
        for (int i = 0; i < burst - 1; i++) begin
          x = ACC_W'($urandom_range(0, 64) - 32);
          y = ACC_W'(-$urandom_range(16384, 32768));
          send_sample(x, y);
        end
        sent = burst;
        x = ACC_W'($urandom_range(0, 64) - 32);
        y = ACC_W'(-$urandom_range(16384, 32768));
      end
      8: begin
        x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      default: begin
        x = ACC_W'($urandom);
        y = ACC_W'($urandom);
      end
    endcase
    send_sample(x, y);
  endtask

  initial begin
    int sent;
    int count;
    rst_n          = 1'b0;
    steady         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.idx    = '0;
    cfg_bus.data   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sh7FFF, 16'sd0);
    send_sample(16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    drain();

    // full gain, origin at zero, longest pointer: low clamp and unwrap
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_CX, 16'hFF80);
    write_reg(CFG_CY, 16'hFFC0);
    write_reg(CFG_LEN, 16'h003F);
    write_reg(CFG_NONE, 16'h1234);
    send_sample(16'sd1, 16'sh8000);
    send_sample(-16'sd1, 16'sh8000);
    send_sample(16'sd1, 16'sh8000);
    send_sample(16'sd0, -16'sd5);
    send_sample(16'sh8000, -16'sd1);
    send_sample(16'sh7FFF, -16'sd1);
    send_sample(-16'sd7, 16'sd3);
    drain();

    // frozen filter, zero length, far corner
    write_reg(CFG_GAIN, 16'h0000);
    write_reg(CFG_CX, 16'hFFFF);
    write_reg(CFG_CY, 16'hFFFF);
    write_reg(CFG_LEN, 16'hFFC0);
    write_reg(CFG_TOP, 16'hFFFF);
    send_sample(16'sd12345, -16'sd2222);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd0, 16'sd0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        write_reg(CFG_GAIN, 16'd6554);
        write_reg(CFG_CX, 16'd64);
        write_reg(CFG_CY, 16'd32);
        write_reg(CFG_LEN, 16'd32);
      end else begin
        random_config();
      end
      steady = (phase == 2);
      count  = 0;
      while (count < PHASE_SAMPLES) begin
        random_sample(sent);
        count += sent;
      end
      drain();
      steady = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
